### sv/pic8259_pkg.sv
// ----------------------------------------------------------------------------
// pic8259_pkg
// shared types and constants of the 8-line interrupt controller
// ----------------------------------------------------------------------------
package pic8259_pkg;

  localparam int unsigned LINE_W = 8;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_ACK    = 2'd3
  } cmd_t;

  // init word sequencer, one-hot
  typedef enum logic [3:0] {
    INIT_READY = 4'b0001,
    INIT_ICW2  = 4'b0010,
    INIT_ICW3  = 4'b0100,
    INIT_ICW4  = 4'b1000
  } init_t;

  // command byte decode
  localparam int unsigned ICW1_BIT = 4;
  localparam int unsigned IC4_BIT  = 0;
  localparam int unsigned SNGL_BIT = 1;
  localparam int unsigned OCW3_BIT = 3;
  localparam int unsigned RR_BIT   = 1;
  localparam int unsigned RIS_BIT  = 0;

  localparam logic [2:0] OCW2_NSEOI = 3'b001;
  localparam logic [2:0] OCW2_SEOI  = 3'b011;
  localparam logic [2:0] SPUR_LINE  = 3'd7;

  localparam logic [LINE_W-1:0] MASK_RESET = 8'hFF;

  typedef struct packed {
    cmd_t              cmd;
    logic              port_sel;
    logic [LINE_W-1:0] wdata;
    logic [LINE_W-1:0] lines;
  } item_t;

  typedef struct packed {
    logic [LINE_W-1:0] rdata;
    logic              int_request;
    logic [7:0]        vector;
    logic              spurious;
    logic              init_busy;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] line;
  } win_t;

endpackage

### sv/pic8259_prio.sv
// ----------------------------------------------------------------------------
// pic8259_prio
// fixed-priority resolver, line 0 highest, in-service lines block lower ones
// ----------------------------------------------------------------------------
module pic8259_prio (
  input  logic [pic8259_pkg::LINE_W-1:0] irr,
  input  logic [pic8259_pkg::LINE_W-1:0] imr,
  input  logic [pic8259_pkg::LINE_W-1:0] isr,
  input  logic                           busy,
  output pic8259_pkg::win_t              win
);

  logic [pic8259_pkg::LINE_W-1:0] pend;
  logic [pic8259_pkg::LINE_W-1:0] isr_low;
  logic [pic8259_pkg::LINE_W-1:0] above;
  logic [pic8259_pkg::LINE_W-1:0] elig;

  // lines strictly above the highest-priority in-service line (all when none)
  assign pend    = irr & ~imr;
  assign isr_low = isr & (~isr + 8'd1);
  assign above   = isr_low - 8'd1;
  assign elig    = pend & above;

  always_comb begin
    win.valid = !busy && (elig != '0);
    win.line  = 3'd0;
    for (int i = pic8259_pkg::LINE_W - 1; i >= 0; i--) begin
      if (elig[i]) begin
        win.line = 3'(i);
      end
    end
  end

endmodule

### sv/pic8259_core.sv
// ----------------------------------------------------------------------------
// pic8259_core
// controller registers and the single-pass update for one transaction
// ----------------------------------------------------------------------------
module pic8259_core #(
  parameter int unsigned NUM_LINES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  pic8259_pkg::item_t   item,
  output pic8259_pkg::result_t res
);

  localparam logic [pic8259_pkg::LINE_W-1:0] LineMask =
    pic8259_pkg::LINE_W'((16'd1 << NUM_LINES) - 16'd1);

  logic [pic8259_pkg::LINE_W-1:0] irr, irr_next;
  logic [pic8259_pkg::LINE_W-1:0] isr, isr_next;
  logic [pic8259_pkg::LINE_W-1:0] imr, imr_next;
  logic [4:0]                     vbase, vbase_next;
  pic8259_pkg::init_t             init_step, init_step_next;
  logic                           needs_icw4, needs_icw4_next;
  logic                           single_mode, single_mode_next;
  logic                           read_isr, read_isr_next;
  logic [pic8259_pkg::LINE_W-1:0] cascade_word, cascade_word_next;
  logic [pic8259_pkg::LINE_W-1:0] prev_lines, prev_lines_next;

  logic [pic8259_pkg::LINE_W-1:0] rising;
  logic [pic8259_pkg::LINE_W-1:0] win_bit;
  pic8259_pkg::win_t              win_now;
  pic8259_pkg::win_t              win_after;

  pic8259_prio u_prio_now (
    .irr  (irr),
    .imr  (imr),
    .isr  (isr),
    .busy (init_step != pic8259_pkg::INIT_READY),
    .win  (win_now)
  );

  pic8259_prio u_prio_after (
    .irr  (irr_next),
    .imr  (imr_next),
    .isr  (isr_next),
    .busy (init_step_next != pic8259_pkg::INIT_READY),
    .win  (win_after)
  );

  assign rising  = item.lines & ~prev_lines & LineMask;
  assign win_bit = 8'd1 << win_now.line;

  always_comb begin
    irr_next          = irr;
    isr_next          = isr;
    imr_next          = imr;
    vbase_next        = vbase;
    init_step_next    = init_step;
    needs_icw4_next   = needs_icw4;
    single_mode_next  = single_mode;
    read_isr_next     = read_isr;
    cascade_word_next = cascade_word;
    prev_lines_next   = prev_lines;
    res               = '0;

    unique case (item.cmd)
      pic8259_pkg::CMD_WRITE: begin
        if (!item.port_sel) begin
          if (item.wdata[pic8259_pkg::ICW1_BIT]) begin
            needs_icw4_next  = item.wdata[pic8259_pkg::IC4_BIT];
            single_mode_next = item.wdata[pic8259_pkg::SNGL_BIT];
            imr_next         = '0;
            irr_next         = '0;
            isr_next         = '0;
            read_isr_next    = 1'b0;
            init_step_next   = pic8259_pkg::INIT_ICW2;
          end else if (init_step == pic8259_pkg::INIT_READY) begin
            priority if (item.wdata[pic8259_pkg::OCW3_BIT]) begin
              if (item.wdata[pic8259_pkg::RR_BIT]) begin
                read_isr_next = item.wdata[pic8259_pkg::RIS_BIT];
              end
            end else if (item.wdata[7:5] == pic8259_pkg::OCW2_NSEOI) begin
              // clear highest-priority in-service bit
              isr_next = isr & ~(isr & (~isr + 8'd1));
            end else if (item.wdata[7:5] == pic8259_pkg::OCW2_SEOI) begin
              isr_next = isr & ~(8'd1 << item.wdata[2:0]);
            end else begin
              // other ocw2 codes leave the state alone
            end
          end
        end else begin
          unique case (init_step)
            pic8259_pkg::INIT_ICW2: begin
              vbase_next = item.wdata[7:3];
              if (!single_mode) begin
                init_step_next = pic8259_pkg::INIT_ICW3;
              end else if (needs_icw4) begin
                init_step_next = pic8259_pkg::INIT_ICW4;
              end else begin
                init_step_next = pic8259_pkg::INIT_READY;
              end
            end
            pic8259_pkg::INIT_ICW3: begin
              cascade_word_next = item.wdata;
              init_step_next    = needs_icw4 ? pic8259_pkg::INIT_ICW4
                                             : pic8259_pkg::INIT_READY;
            end
            pic8259_pkg::INIT_ICW4: begin
              init_step_next = pic8259_pkg::INIT_READY;
            end
            default: begin
              imr_next = item.wdata;
            end
          endcase
        end
      end
      pic8259_pkg::CMD_READ: begin
        if (item.port_sel) begin
          res.rdata = imr;
        end else begin
          res.rdata = read_isr ? isr : irr;
        end
      end
      pic8259_pkg::CMD_SAMPLE: begin
        irr_next        = (irr | rising) & item.lines;
        prev_lines_next = item.lines;
      end
      default: begin
        if (win_now.valid) begin
          isr_next   = isr | win_bit;
          irr_next   = irr & ~win_bit;
          res.vector = {vbase, win_now.line};
        end else begin
          res.vector   = {vbase, pic8259_pkg::SPUR_LINE};
          res.spurious = 1'b1;
        end
      end
    endcase

    res.int_request = win_after.valid;
    res.init_busy   = (init_step_next != pic8259_pkg::INIT_READY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irr          <= '0;
      isr          <= '0;
      imr          <= pic8259_pkg::MASK_RESET;
      vbase        <= '0;
      init_step    <= pic8259_pkg::INIT_READY;
      needs_icw4   <= 1'b0;
      single_mode  <= 1'b0;
      read_isr     <= 1'b0;
      cascade_word <= '0;
      prev_lines   <= '0;
    end else if (advance) begin
      irr          <= irr_next;
      isr          <= isr_next;
      imr          <= imr_next;
      vbase        <= vbase_next;
      init_step    <= init_step_next;
      needs_icw4   <= needs_icw4_next;
      single_mode  <= single_mode_next;
      read_isr     <= read_isr_next;
      cascade_word <= cascade_word_next;
      prev_lines   <= prev_lines_next;
    end
  end

endmodule

### sv/interrupt_controller_8259_top.sv
// ----------------------------------------------------------------------------
// interrupt_controller_8259_top
// single 8-line programmable interrupt controller with valid/ready channels
// ----------------------------------------------------------------------------
// Each input transaction is a bus write, a bus read, a sample of the request
// lines or an interrupt acknowledge, and yields exactly one result
// transaction. The block takes one transaction per clock cycle when the
// output side keeps up; a transaction passes an input register, then one
// pass of update logic writes the controller registers and the result
// register together, and the result register offers the result. The
// rate is set by that single update pass, which must finish before the next
// transaction reads the controller registers. A waiting result does not stop
// intake: one more transaction can sit in the input register behind it.
// Priority is fixed with line 0 highest; lines at or above NUM_LINES never
// latch a request.
module interrupt_controller_8259_top #(
  parameter int unsigned NUM_LINES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic       port_sel,
  input  logic [7:0] wdata,
  input  logic [7:0] request_lines,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] rdata,
  output logic       int_request,
  output logic [7:0] vector,
  output logic       spurious,
  output logic       init_busy
);

  // input register
  logic                 s1_valid;
  pic8259_pkg::item_t   s1_item;
  // result register
  pic8259_pkg::result_t out_res;
  pic8259_pkg::result_t core_res;
  // transaction moves from input register into the result register
  logic                 advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.cmd      <= pic8259_pkg::cmd_t'(cmd);
      s1_item.port_sel <= port_sel;
      s1_item.wdata    <= wdata;
      s1_item.lines    <= request_lines;
    end
  end

  // controller state and single-pass update
  pic8259_core #(
    .NUM_LINES (NUM_LINES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign rdata       = out_res.rdata;
  assign int_request = out_res.int_request;
  assign vector      = out_res.vector;
  assign spurious    = out_res.spurious;
  assign init_busy   = out_res.init_busy;

`ifndef SYNTHESIS
  // a spurious acknowledge always hands out the line-7 vector
  a_spur_vec: assert property (@(posedge clk) disable iff (rst)
    out_valid && spurious |-> vector[2:0] == pic8259_pkg::SPUR_LINE)
    else $error("spurious result without line-7 vector");

  // interrupt output is held low while initialization is pending
  a_busy_noint: assert property (@(posedge clk) disable iff (rst)
    out_valid && init_busy |-> !int_request)
    else $error("interrupt raised during initialization");

  // a transaction that leaves the input register shows up as a result
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("transaction lost between input and result register");

  // empty input register never refuses a transaction
  a_intake: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("intake stalled with empty input register");
`endif

endmodule

### verif/tb_interrupt_controller_8259_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interrupt_controller_8259_top
// self-checking bench for the 8-line interrupt controller
// ----------------------------------------------------------------------------
// A directed table runs first: reset values, init word sequences in cascade
// and single mode, masking, acknowledge with and without a winner, both EOI
// forms, ISR read select and dropped requests. A long random stream follows,
// built mostly from well-formed init sequences, line toggles, acknowledges and
// EOIs, with some noise mixed in. Every accepted transaction runs through a
// local model of the controller and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_interrupt_controller_8259_top;

  localparam int unsigned NUM_LINES   = 8;
  localparam logic [7:0]  LINE_MASK   = 8'((1 << NUM_LINES) - 1);
  localparam int unsigned RANDOM_N    = 700;
  localparam int unsigned SETTLE_N    = 8;
  localparam int unsigned CYCLE_LIMIT = 60000;

  // bus side
  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] cmd;
  logic       port_sel;
  logic [7:0] wdata;
  logic [7:0] request_lines;
  // result side
  logic       out_valid;
  logic       out_ready;
  logic [7:0] rdata;
  logic       int_request;
  logic [7:0] vector;
  logic       spurious;
  logic       init_busy;

  // one stimulus row, with an optional hand-written expected result
  typedef struct {
    pic8259_pkg::item_t   it;
    bit                   typed;
    pic8259_pkg::result_t want;
  } bus_row_t;

  bus_row_t             bus_rows[$];
  pic8259_pkg::result_t pending_results[$];
  int unsigned          directed_rows;
  int unsigned          feed_idle_pct;
  int unsigned          drain_idle_pct;
  int unsigned          mismatch_count = 0;
  int unsigned          results_seen = 0;
  int unsigned          cycle_count = 0;

  // controller state as the bench sees it
  logic [7:0]         irr_q;
  logic [7:0]         isr_q;
  logic [7:0]         imr_q;
  logic [4:0]         vbase_q;
  pic8259_pkg::init_t seq_q;
  logic               want_icw4_q;
  logic               single_q;
  logic               read_isr_q;
  logic [7:0]         cascade_q;
  logic [7:0]         prev_lines_q;

  interrupt_controller_8259_top #(
    .NUM_LINES(NUM_LINES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .port_sel     (port_sel),
    .wdata        (wdata),
    .request_lines(request_lines),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rdata        (rdata),
    .int_request  (int_request),
    .vector       (vector),
    .spurious     (spurious),
    .init_busy    (init_busy)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // controller model
  // --------------------------------------------------------------------------

  // index of the lowest set bit, 8 when empty (line 0 wins)
  function automatic int unsigned first_set(logic [7:0] v);
    for (int unsigned i = 0; i < 8; i++)
      if (v[i]) return i;
    return 8;
  endfunction

  // line that may raise the interrupt now, 8 when none
  function automatic int unsigned eligible_line();
    int unsigned p;
    int unsigned s;
    if (seq_q != pic8259_pkg::INIT_READY) return 8;
    p = first_set(irr_q & ~imr_q);
    s = first_set(isr_q);
    return (p < s) ? p : 8;
  endfunction

  task automatic reset_pic_state();
    irr_q        = '0;
    isr_q        = '0;
    imr_q        = pic8259_pkg::MASK_RESET;
    vbase_q      = '0;
    seq_q        = pic8259_pkg::INIT_READY;
    want_icw4_q  = 1'b0;
    single_q     = 1'b0;
    read_isr_q   = 1'b0;
    cascade_q    = '0;
    prev_lines_q = '0;
  endtask

  // advance the model by one transaction and return what the block must give
  task automatic predict_pic_result(input pic8259_pkg::item_t it,
                                    output pic8259_pkg::result_t r);
    int unsigned w;
    logic [7:0]  rising;
    r = '0;
    case (it.cmd)
      pic8259_pkg::CMD_WRITE: begin
        if (!it.port_sel) begin
          if (it.wdata[pic8259_pkg::ICW1_BIT]) begin
            // icw1 restarts init from any state
            want_icw4_q = it.wdata[pic8259_pkg::IC4_BIT];
            single_q    = it.wdata[pic8259_pkg::SNGL_BIT];
            imr_q       = '0;
            irr_q       = '0;
            isr_q       = '0;
            read_isr_q  = 1'b0;
            seq_q       = pic8259_pkg::INIT_ICW2;
          end else if (seq_q == pic8259_pkg::INIT_READY) begin
            if (it.wdata[pic8259_pkg::OCW3_BIT]) begin
              if (it.wdata[pic8259_pkg::RR_BIT])
                read_isr_q = it.wdata[pic8259_pkg::RIS_BIT];
            end else if (it.wdata[7:5] == pic8259_pkg::OCW2_NSEOI) begin
              w = first_set(isr_q);
              if (w < 8) isr_q[w] = 1'b0;
            end else if (it.wdata[7:5] == pic8259_pkg::OCW2_SEOI) begin
              isr_q[it.wdata[2:0]] = 1'b0;
            end
          end
        end else begin
          case (seq_q)
            pic8259_pkg::INIT_ICW2: begin
              vbase_q = it.wdata[7:3];
              if (!single_q) seq_q = pic8259_pkg::INIT_ICW3;
              else if (want_icw4_q) seq_q = pic8259_pkg::INIT_ICW4;
              else seq_q = pic8259_pkg::INIT_READY;
            end
            pic8259_pkg::INIT_ICW3: begin
              cascade_q = it.wdata;
              if (want_icw4_q) seq_q = pic8259_pkg::INIT_ICW4;
              else seq_q = pic8259_pkg::INIT_READY;
            end
            pic8259_pkg::INIT_ICW4: seq_q = pic8259_pkg::INIT_READY;
            default:                imr_q = it.wdata;
          endcase
        end
      end
      pic8259_pkg::CMD_READ: begin
        if (it.port_sel) r.rdata = imr_q;
        else r.rdata = read_isr_q ? isr_q : irr_q;
      end
      pic8259_pkg::CMD_SAMPLE: begin
        rising       = it.lines & ~prev_lines_q & LINE_MASK;
        irr_q        = (irr_q | rising) & it.lines;
        prev_lines_q = it.lines;
      end
      default: begin
        w = eligible_line();
        if (w < 8) begin
          isr_q[w] = 1'b1;
          irr_q[w] = 1'b0;
          r.vector = {vbase_q, 3'(w)};
        end else begin
          r.vector   = {vbase_q, pic8259_pkg::SPUR_LINE};
          r.spurious = 1'b1;
        end
      end
    endcase
    r.int_request = (eligible_line() < 8);
    r.init_busy   = (seq_q != pic8259_pkg::INIT_READY);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  function automatic pic8259_pkg::result_t res(logic [7:0] rd, logic irq,
                                               logic [7:0] vec, logic spur,
                                               logic busy);
    pic8259_pkg::result_t r;
    r.rdata       = rd;
    r.int_request = irq;
    r.vector      = vec;
    r.spurious    = spur;
    r.init_busy   = busy;
    return r;
  endfunction

  task automatic add_row(pic8259_pkg::cmd_t c, logic p, logic [7:0] d, logic [7:0] l,
                         bit typed = 1'b0, pic8259_pkg::result_t want = '0);
    bus_row_t row;
    row.it.cmd      = c;
    row.it.port_sel = p;
    row.it.wdata    = d;
    row.it.lines    = l;
    row.typed       = typed;
    row.want        = want;
    bus_rows.push_back(row);
  endtask

  // mostly sparse masks so requests get through
  function automatic logic [7:0] mask_byte();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 8'($urandom);
      default: return 8'($urandom) & 8'($urandom) & 8'($urandom);
    endcase
  endfunction

  // occasional garbage inside an init sequence
  task automatic add_junk_rows();
    int unsigned k;
    if ($urandom_range(99) < 15) begin
      k = $urandom_range(1, 3);
      repeat (k)
        add_row(pic8259_pkg::cmd_t'($urandom_range(3)), 1'($urandom),
                8'($urandom), 8'($urandom));
    end
  endtask

  task automatic add_directed_rows();
    // after reset: mask all ones, nothing pending, ack is spurious
    add_row(pic8259_pkg::CMD_READ,   1'b1, 8'h00, 8'h00, 1'b1,
            res(8'hFF, 1'b0, 8'h00, 1'b0, 1'b0));
    add_row(pic8259_pkg::CMD_READ,   1'b0, 8'h00, 8'h00, 1'b1,
            res(8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
    add_row(pic8259_pkg::CMD_ACK,    1'b0, 8'h00, 8'h00, 1'b1,
            res(8'h00, 1'b0, 8'h07, 1'b1, 1'b0));
    // all lines rise while masked
    add_row(pic8259_pkg::CMD_SAMPLE, 1'b0, 8'h00, 8'hFF, 1'b1,
            res(8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
    // cascade init with icw4, ack and ocw2 during init
    add_row(pic8259_pkg::CMD_WRITE,  1'b0, 8'h11, 8'h00, 1'b1,
            res(8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
    add_row(pic8259_pkg::CMD_ACK,    1'b0, 8'h00, 8'h00, 1'b1,
            res(8'h00, 1'b0, 8'h07, 1'b1, 1'b1));
    add_row(pic8259_pkg::CMD_WRITE,  1'b0, 8'h20, 8'h00, 1'b1,
            res(8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
    add_row(pic8259_pkg::CMD_WRITE,  1'b1, 8'hFF, 8'h00, 1'b1,
            res(8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
    add_row(pic8259_pkg::CMD_WRITE,  1'b1, 8'h00, 8'h00, 1'b1,
            res(8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
    add_row(pic8259_pkg::CMD_WRITE,  1'b1, 8'h00, 8'h00, 1'b1,
            res(8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
    // lines low then all high: every line latches
    add_row(pic8259_pkg::CMD_SAMPLE, 1'b0, 8'h00, 8'h00);
    add_row(pic8259_pkg::CMD_SAMPLE, 1'b0, 8'h00, 8'hFF);
    add_row(pic8259_pkg::CMD_ACK,    1'b0, 8'h00, 8'hFF);
    // line 0 in service blocks all lower lines
    add_row(pic8259_pkg::CMD_ACK,    1'b0, 8'h00, 8'hFF);
    add_row(pic8259_pkg::CMD_WRITE,  1'b0, 8'h0B, 8'hFF);
    add_row(pic8259_pkg::CMD_READ,   1'b0, 8'h00, 8'hFF);
    add_row(pic8259_pkg::CMD_WRITE,  1'b0, 8'h20, 8'hFF);
    add_row(pic8259_pkg::CMD_ACK,    1'b0, 8'h00, 8'hFF);
    add_row(pic8259_pkg::CMD_WRITE,  1'b0, 8'h61, 8'hFF);
    // falling lines drop latched requests
    add_row(pic8259_pkg::CMD_SAMPLE, 1'b0, 8'h00, 8'h00);
    add_row(pic8259_pkg::CMD_WRITE,  1'b1, 8'hFF, 8'h00);
    // single mode with and without icw4
    add_row(pic8259_pkg::CMD_WRITE,  1'b0, 8'h13, 8'h00);
    add_row(pic8259_pkg::CMD_WRITE,  1'b1, 8'h00, 8'h00);
    add_row(pic8259_pkg::CMD_WRITE,  1'b1, 8'h5A, 8'h00);
    add_row(pic8259_pkg::CMD_WRITE,  1'b0, 8'h12, 8'h00);
    add_row(pic8259_pkg::CMD_WRITE,  1'b1, 8'h07, 8'h00);
  endtask

  task automatic add_random_rows(int unsigned total);
    logic [7:0]  levels;
    logic [7:0]  b;
    int unsigned pick;
    levels = '0;
    while (bus_rows.size() < total) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        // full init sequence, sometimes broken up by junk
        b = 8'($urandom) | (8'h01 << pic8259_pkg::ICW1_BIT);
        add_row(pic8259_pkg::CMD_WRITE, 1'b0, b, 8'($urandom));
        add_junk_rows();
        add_row(pic8259_pkg::CMD_WRITE, 1'b1, 8'($urandom), 8'($urandom));
        if (!b[pic8259_pkg::SNGL_BIT]) begin
          add_junk_rows();
          add_row(pic8259_pkg::CMD_WRITE, 1'b1, 8'($urandom), 8'($urandom));
        end
        if (b[pic8259_pkg::IC4_BIT]) begin
          add_junk_rows();
          add_row(pic8259_pkg::CMD_WRITE, 1'b1, 8'($urandom), 8'($urandom));
        end
        add_row(pic8259_pkg::CMD_WRITE, 1'b1, mask_byte(), 8'($urandom));
      end else if (pick < 34) begin
        // line activity: single toggles give clean edges
        case ($urandom_range(9))
          0, 1, 2, 3, 4: levels ^= 8'h01 << $urandom_range(7);
          5, 6, 7:       levels ^= 8'($urandom) & 8'($urandom);
          default:       levels = 8'($urandom);
        endcase
        add_row(pic8259_pkg::CMD_SAMPLE, 1'($urandom), 8'($urandom), levels);
      end else if (pick < 59) begin
        add_row(pic8259_pkg::CMD_ACK, 1'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 71) begin
        add_row(pic8259_pkg::CMD_READ, 1'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 80) begin
        add_row(pic8259_pkg::CMD_WRITE, 1'b1, mask_byte(), 8'($urandom));
      end else if (pick < 88) begin
        b = {($urandom_range(1) != 0) ? pic8259_pkg::OCW2_NSEOI : pic8259_pkg::OCW2_SEOI,
             2'b00, 3'($urandom)};
        add_row(pic8259_pkg::CMD_WRITE, 1'b0, b, 8'($urandom));
      end else if (pick < 94) begin
        // ocw3: bit 3 set, bit 4 clear
        add_row(pic8259_pkg::CMD_WRITE, 1'b0, {3'($urandom), 2'b01, 3'($urandom)},
                8'($urandom));
      end else if (pick < 98) begin
        // ocw2 codes that do nothing
        do b[7:5] = 3'($urandom);
        while (b[7:5] == pic8259_pkg::OCW2_NSEOI || b[7:5] == pic8259_pkg::OCW2_SEOI);
        b[4:0] = {2'b00, 3'($urandom)};
        add_row(pic8259_pkg::CMD_WRITE, 1'b0, b, 8'($urandom));
      end else begin
        add_row(pic8259_pkg::cmd_t'($urandom_range(3)), 1'($urandom), 8'($urandom),
                8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("result %0d %s: expected %02h got %02h", results_seen, what, want, got);
    mismatch_count++;
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    pic8259_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, rdata", 8'h00, rdata);
      end else begin
        want = pending_results.pop_front();
        if (rdata !== want.rdata) flag_mismatch("rdata", want.rdata, rdata);
        if (int_request !== want.int_request)
          flag_mismatch("int_request", 8'(want.int_request), 8'(int_request));
        if (vector !== want.vector) flag_mismatch("vector", want.vector, vector);
        if (spurious !== want.spurious)
          flag_mismatch("spurious", 8'(want.spurious), 8'(spurious));
        if (init_busy !== want.init_busy)
          flag_mismatch("init_busy", 8'(want.init_busy), 8'(init_busy));
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[interrupt_controller_8259_top] ERROR");
    $finish;
  end

  // result side back-pressure, redrawn every cycle
  initial begin
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= drain_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // bus side driver
  // --------------------------------------------------------------------------
  initial begin : feed
    int unsigned          idx;
    int unsigned          n;
    int unsigned          phase;
    pic8259_pkg::result_t r;
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = pic8259_pkg::CMD_READ;
    port_sel       = 1'b0;
    wdata          = '0;
    request_lines  = '0;
    // sender mostly busy, receiver mostly stalled to start
    feed_idle_pct  = 13;
    drain_idle_pct = 80;
    reset_pic_state();
    add_directed_rows();
    directed_rows = bus_rows.size();
    add_random_rows(directed_rows + RANDOM_N);
    n = bus_rows.size();
    phase = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (idx = 0; idx < n; idx++) begin
      // drain everything at the end of the table and at each phase change
      if (idx == directed_rows || (idx * 3) / n != phase) begin
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        if ((idx * 3) / n != phase) begin
          phase = (idx * 3) / n;
          if (phase == 1) begin
            feed_idle_pct  = 80;
            drain_idle_pct = 13;
          end else begin
            feed_idle_pct  = 0;
            drain_idle_pct = 0;
          end
        end
      end
      while ($urandom_range(99) < feed_idle_pct) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
      cmd           = bus_rows[idx].it.cmd;
      port_sel      = bus_rows[idx].it.port_sel;
      wdata         = bus_rows[idx].it.wdata;
      request_lines = bus_rows[idx].it.lines;
      in_valid      = 1'b1;
      do @(posedge clk);
      while (!in_ready);
      // transaction accepted at this edge
      predict_pic_result(bus_rows[idx].it, r);
      pending_results.push_back(bus_rows[idx].typed ? bus_rows[idx].want : r);
      @(negedge clk);
    end
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray result behind the last one
    repeat (SETTLE_N) @(posedge clk);
    if (mismatch_count == 0)
      $display("[interrupt_controller_8259_top] OK");
    else
      $display("[interrupt_controller_8259_top] ERROR");
    $finish;
  end

endmodule
